### rtl/jkv_pkg.sv
// shared types, constants and character codes for the json key/value scanner
`default_nettype none
package jkv_pkg;

    localparam int KEY_MAX     = 16;
    localparam int OFFSET_BITS = 24;
    localparam int DEPTH_MAX   = 255;

    localparam int WIN_LEN  = KEY_MAX + 2;
    localparam int KLEN_W   = $clog2(KEY_MAX + 1);
    localparam int KIDX_W   = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int DEPTH_W  = $clog2(DEPTH_MAX + 1);
    localparam int START_W  = 24;
    localparam int NUM_W    = 32;
    localparam int CFG_W    = 64;
    localparam int IDX_W    = 2;

    localparam logic [OFFSET_BITS-1:0] POS_MAX     = '1;
    localparam logic [DEPTH_W-1:0]     DEPTH_LIMIT = DEPTH_W'(DEPTH_MAX);
    localparam logic [NUM_W-1:0]       DEC_BASE    = NUM_W'(10);

    // register indexes
    localparam logic [IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [IDX_W-1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [IDX_W-1:0] REG_KEY_LEN  = 2'd2;

    // reset values of the key registers ("id")
    localparam logic [CFG_W-1:0]  KEY_LOW_RST  = 64'd25705;
    localparam logic [CFG_W-1:0]  KEY_HIGH_RST = 64'd0;
    localparam logic [KLEN_W-1:0] KEY_LEN_RST  = KLEN_W'(2);

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_VALUE  = 2'd1,
        PH_DONE   = 2'd2
    } jkv_phase_t;

    // one accepted byte as seen by the value walker
    typedef struct packed {
        logic       take;
        logic       end_msg;
        logic       key_hit;
        logic [7:0] data;
    } jkv_step_t;

    typedef struct packed {
        logic [START_W-1:0] value_start;
        logic [START_W-1:0] value_length;
        logic [NUM_W-1:0]   leading_number;
        logic               saturated;
    } jkv_result_t;

endpackage
`default_nettype wire

### rtl/jkv_if.sv
// channel interfaces: message bytes in, scan results out
`default_nettype none
interface jkv_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface jkv_result_if import jkv_pkg::*;;
    logic               valid;
    logic               ready;
    logic [START_W-1:0] value_start;
    logic [START_W-1:0] value_length;
    logic [NUM_W-1:0]   leading_number;
    logic               saturated;

    modport source (output valid, output value_start, output value_length,
                    output leading_number, output saturated, input ready);
    modport sink   (input valid, input value_start, input value_length,
                    input leading_number, input saturated, output ready);
endinterface
`default_nettype wire

### rtl/jkv_cell.sv
// one window cell: holds a recent byte, shifts it on, compares it to its pattern byte
`default_nettype none
module jkv_cell
    import jkv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       shift_en,
    input  wire logic       clear,
    input  wire logic [7:0] prev_byte,
    input  wire logic [7:0] expect_byte,
    input  wire logic       care,
    output logic      [7:0] cur_byte,
    output logic            hit
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (clear)
        begin
            byte_next = CH_NUL;
        end
        else if (shift_en)
        begin
            byte_next = prev_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= CH_NUL;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign cur_byte = byte_reg;
    assign hit      = !care || (byte_reg == expect_byte);

endmodule
`default_nettype wire

### rtl/jkv_walker.sv
// scan phase, position and value walk: string, escape, depth and leading number
`default_nettype none
module jkv_walker
    import jkv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire jkv_step_t   step,
    output jkv_result_t      res
);

    jkv_phase_t               state_reg, state_next;
    logic [DEPTH_W-1:0]       depth_reg, depth_next;
    logic                     in_str_reg, in_str_next;
    logic                     esc_reg, esc_next;
    logic [OFFSET_BITS-1:0]   pos_reg, pos_next;
    logic [OFFSET_BITS-1:0]   start_reg, start_next;
    logic [OFFSET_BITS-1:0]   end_reg, end_next;
    logic [NUM_W-1:0]         accum_reg, accum_next;
    logic                     digits_reg, digits_next;
    logic                     ovf_reg, ovf_next;

    logic                     is_digit;
    logic [OFFSET_BITS-1:0]   pos_inc;
    logic [OFFSET_BITS-1:0]   end_pos;
    logic [OFFSET_BITS-1:0]   len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= PH_SEARCH;
            depth_reg  <= '0;
            in_str_reg <= 1'b0;
            esc_reg    <= 1'b0;
            pos_reg    <= '0;
            start_reg  <= '0;
            end_reg    <= '0;
            accum_reg  <= '0;
            digits_reg <= 1'b1;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            depth_reg  <= depth_next;
            in_str_reg <= in_str_next;
            esc_reg    <= esc_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            end_reg    <= end_next;
            accum_reg  <= accum_next;
            digits_reg <= digits_next;
            ovf_reg    <= ovf_next;
        end
    end

    assign is_digit = (step.data >= CH_ZERO) && (step.data <= CH_NINE);
    assign pos_inc  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        depth_next  = depth_reg;
        in_str_next = in_str_reg;
        esc_next    = esc_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        accum_next  = accum_reg;
        digits_next = digits_reg;
        ovf_next    = ovf_reg;

        if (step.take && step.end_msg)
        begin
            state_next  = PH_SEARCH;
            depth_next  = '0;
            in_str_next = 1'b0;
            esc_next    = 1'b0;
            pos_next    = '0;
            start_next  = '0;
            end_next    = '0;
            accum_next  = '0;
            digits_next = 1'b1;
            ovf_next    = 1'b0;
        end
        else if (step.take)
        begin
            pos_next = pos_inc;
            if (pos_reg == POS_MAX)
            begin
                ovf_next = 1'b1;
            end

            unique case (state_reg)
                PH_SEARCH:
                begin
                    if (step.key_hit)
                    begin
                        state_next = PH_VALUE;
                        start_next = pos_inc;
                    end
                end
                PH_VALUE:
                begin
                    if (digits_reg)
                    begin
                        if (is_digit)
                        begin
                            accum_next = NUM_W'(accum_reg * DEC_BASE)
                                       + NUM_W'(step.data[3:0]);
                        end
                        else
                        begin
                            digits_next = 1'b0;
                        end
                    end

                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                    end
                    else if (step.data == CH_BSLASH)
                    begin
                        esc_next = 1'b1;
                    end
                    else if (step.data == CH_QUOTE)
                    begin
                        in_str_next = !in_str_reg;
                    end
                    else if (!in_str_reg)
                    begin
                        if (step.data == CH_LBRACE || step.data == CH_LBRACK)
                        begin
                            if (depth_reg >= DEPTH_LIMIT)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                depth_next = depth_reg + 1'b1;
                            end
                        end
                        else if (step.data == CH_RBRACE || step.data == CH_RBRACK)
                        begin
                            if (depth_reg == '0)
                            begin
                                state_next = PH_DONE;
                                end_next   = pos_reg;
                            end
                            else
                            begin
                                depth_next = depth_reg - 1'b1;
                            end
                        end
                        else if (step.data == CH_COMMA && depth_reg == '0)
                        begin
                            state_next = PH_DONE;
                            end_next   = pos_reg;
                        end
                    end
                end
                PH_DONE:
                begin
                end
                default:
                begin
                    state_next = PH_SEARCH;
                end
            endcase
        end
    end

    // result for a message that ends now
    assign end_pos = (state_reg == PH_VALUE) ? pos_reg : end_reg;
    assign len     = (state_reg == PH_SEARCH) ? '0 : end_pos - start_reg;

    always_comb
    begin
        res.value_length   = START_W'(len);
        res.value_start    = (len != '0) ? START_W'(start_reg) : '0;
        res.leading_number = (len != '0) ? accum_reg : '0;
        res.saturated      = ovf_reg;
    end

endmodule
`default_nettype wire

### rtl/json_top_key_value_scanner_unit.sv
// top level of the json key/value scanner: window cell row, value walker, result register
//
//  channel  dir  beat contents                                        handshake
//  -------  ---  ---------------------------------------------------  ----------------
//  msg      in   data_byte (8), zero ends the message                 valid/ready
//  result   out  value_start (24), value_length (24),                 valid/ready
//                leading_number (32), saturated (1)
//  wr_*     in   wr_index (2), wr_data (64)                           wr_en, no stall
//
// one byte per cycle while msg ready is high; every beat finishes in the cycle it
// is taken, the key compare runs across the window cells in parallel with the value walker
// a zero byte loads the result register at its accepting edge; the result is
// offered from the next cycle on, one per message, back to back
// msg ready drops only while a result sits unaccepted and result ready is low
// reset (async, active low) clears the window, walker state and the result
// valid flag, and loads the reset key "id" with length 2
`default_nettype none
module json_top_key_value_scanner_unit
    import jkv_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    jkv_msg_if.sink               msg,
    jkv_result_if.source          result,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_index,
    input  wire logic [CFG_W-1:0] wr_data
);

    // configuration registers
    logic [CFG_W-1:0]  key_low_reg;
    logic [CFG_W-1:0]  key_high_reg;
    logic [KLEN_W-1:0] key_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= KEY_LOW_RST;
            key_high_reg <= KEY_HIGH_RST;
            key_len_reg  <= KEY_LEN_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_KEY_LOW:  key_low_reg  <= wr_data;
                REG_KEY_HIGH: key_high_reg <= wr_data;
                REG_KEY_LEN:  key_len_reg  <= KLEN_W'(wr_data);
                default:
                begin
                end
            endcase
        end
    end

    // key length clamped to the window, key characters as bytes
    logic [KLEN_W-1:0]          klen;
    logic [KLEN_W:0]            klen_ext;
    logic [2*CFG_W-1:0]         key_all;
    logic [KEY_MAX-1:0][7:0]    key_bytes;

    assign klen      = (key_len_reg > KLEN_W'(KEY_MAX)) ? KLEN_W'(KEY_MAX) : key_len_reg;
    assign klen_ext  = {1'b0, klen};
    assign key_all   = {key_high_reg, key_low_reg};
    assign key_bytes = key_all[KEY_MAX*8-1:0];

    // handshake
    logic take;
    logic end_msg;
    logic out_valid_reg, out_valid_next;

    assign msg.ready = !out_valid_reg || result.ready;
    assign take      = msg.valid && msg.ready;
    assign end_msg   = (msg.data_byte == CH_NUL);

    // window: cell 0 holds the newest byte; the pattern expected across the
    // row is quote, key reversed, quote, cells past that are ignored
    logic [WIN_LEN-1:0][7:0] win_byte;
    logic [WIN_LEN-1:0]      win_hit;
    logic                    key_hit;

    genvar j;
    generate
        for (j = 0; j < WIN_LEN; j++)
        begin : g_cell
            logic [7:0]      prev_byte;
            logic [7:0]      expect_byte;
            logic            care;
            logic [KLEN_W:0] cell_idx;
            logic [KLEN_W:0] key_off;

            assign cell_idx = (KLEN_W+1)'(j);
            assign key_off  = klen_ext - cell_idx;

            if (j == 0)
            begin : g_head
                assign prev_byte = msg.data_byte;
            end
            else
            begin : g_body
                assign prev_byte = win_byte[j-1];
            end

            always_comb
            begin
                expect_byte = CH_QUOTE;
                care        = 1'b0;
                if (cell_idx == '0 || cell_idx == klen_ext + 1'b1)
                begin
                    care = 1'b1;
                end
                else if (cell_idx <= klen_ext)
                begin
                    expect_byte = key_bytes[KIDX_W'(key_off)];
                    care        = 1'b1;
                end
            end

            jkv_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .shift_en    (take && !end_msg),
                .clear       (take && end_msg),
                .prev_byte   (prev_byte),
                .expect_byte (expect_byte),
                .care        (care),
                .cur_byte    (win_byte[j]),
                .hit         (win_hit[j])
            );
        end
    endgenerate

    assign key_hit = (&win_hit) && (msg.data_byte == CH_COLON);

    // value walker
    jkv_step_t   step;
    jkv_result_t walk_res;

    always_comb
    begin
        step.take    = take;
        step.end_msg = end_msg;
        step.key_hit = key_hit;
        step.data    = msg.data_byte;
    end

    jkv_walker u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .res   (walk_res)
    );

    // result register
    jkv_result_t res_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take && end_msg)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (take && end_msg)
        begin
            res_reg <= walk_res;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.value_start    = res_reg.value_start;
    assign result.value_length   = res_reg.value_length;
    assign result.leading_number = res_reg.leading_number;
    assign result.saturated      = res_reg.saturated;

endmodule
`default_nettype wire
